// ----- rtl/core/rc4_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 package
// Shared widths, configuration register indexes and interface structs.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PERM_DEPTH = 256;
  localparam int unsigned CFG_W      = 64;
  localparam int unsigned KEY_W      = 2 * CFG_W;

  // configuration register indexes
  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  // output buffer room, as seen by the engine
  typedef struct packed {
    logic idle_ok;    // a slot is free for an item accepted from idle
    logic finish_ok;  // a slot stays free while the current result is pushed
  } rc4_room_t;

  // one result pushed by the engine
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } rc4_res_t;

endpackage

// ----- rtl/core/rc4_stream_cipher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 stream cipher
// RC4 with a 128-bit key in two configuration registers, one output byte
// for each input byte, key schedule on a byte flagged as restart.
// ----------------------------------------------------------------------------
//
// channel | direction | signals                                   | payload
// --------+-----------+-------------------------------------------+-------------------
// in      | input     | in_valid_i / in_ready_o                   | data_in_i, restart_i
// out     | output    | out_valid_o / out_ready_i                 | data_out_o
// cfg     | input     | cfg_valid_i / cfg_ready_o                 | cfg_index_i, cfg_data_i
//
// a generator byte runs the read of s[i], the read of s[j] and the swap writes
// with the keystream read on the one-read one-write permutation ram; back to
// back the next read of s[i] overlaps the last swap write; a restart byte adds
// the identity fill of all 256 entries, the key schedule and the first read
// reset clears the indices, the key and the output buffer; the ram holds
// no reset value and is filled by the first key schedule
// a two-entry output buffer lets the next byte start while a result waits

module rc4_stream_cipher
  import rc4_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] data_in_i,
  input  logic              restart_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] data_out_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  logic [CFG_W-1:0]  key_low_q;
  logic [CFG_W-1:0]  key_high_q;
  logic [BYTE_W-1:0] buf_q [2];
  logic              wr_ptr_q;
  logic              rd_ptr_q;
  logic [1:0]        count_q, count_d;
  logic              push;
  logic              pop;
  rc4_room_t         room;
  rc4_res_t          res;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_KEY_LOW:  key_low_q  <= cfg_data_i;
        CFG_KEY_HIGH: key_high_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  rc4_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_i      ({key_high_q, key_low_q}),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .data_i     (data_in_i),
    .restart_i  (restart_i),
    .room_i     (room),
    .res_o      (res)
  );

  // output buffer
  assign push        = res.valid;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != 2'd0);
  assign data_out_o  = buf_q[rd_ptr_q];

  assign room.idle_ok   = (count_q != 2'd2);
  assign room.finish_ok = (count_q == 2'd0) || ((count_q == 2'd1) && pop);

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = 2'(count_q + 1'b1);
    end else if (pop && !push) begin
      count_d = 2'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= res.data;
    end
  end

  // checks
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> ((count_q != 2'd2) || pop))
    else $error("result pushed into a full output buffer");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("output buffer count out of range");

  a_ready_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after a transfer");

endmodule

// ----- rtl/core/rc4_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 generic ram
// One write port, one read port, registered read returning the old data
// on a read and write of the same address in one cycle.
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // storage write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/rc4_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 engine
// Sequencer around the permutation ram: identity fill, key schedule and
// keystream generation with swap and read-during-write forwarding.
// ----------------------------------------------------------------------------
module rc4_engine
  import rc4_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [KEY_W-1:0]  key_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] data_i,
  input  logic              restart_i,
  input  rc4_room_t         room_i,
  output rc4_res_t          res_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KA,
    ST_KB,
    ST_KC,
    ST_KD,
    ST_PA,
    ST_PB,
    ST_PC,
    ST_PD
  } state_e;

  localparam logic [BYTE_W-1:0] LastIdx = BYTE_W'(PERM_DEPTH - 1);

  state_e            state_q, state_d;
  logic [BYTE_W-1:0] n_q, n_d;
  logic [BYTE_W-1:0] i_q, i_d;
  logic [BYTE_W-1:0] j_q, j_d;
  logic [BYTE_W-1:0] si_q, si_d;
  logic [BYTE_W-1:0] sj_q, sj_d;
  logic [BYTE_W-1:0] data_q, data_d;
  logic              fwd_q, fwd_d;
  logic              fwd2_q, fwd2_d;
  logic              fwd3_q, fwd3_d;

  logic              ram_we;
  logic [BYTE_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic              accept;
  logic [BYTE_W-1:0] key_byte;
  logic [BYTE_W-1:0] rd_si;
  logic [BYTE_W-1:0] ks;
  logic [BYTE_W-1:0] i_next;
  logic [BYTE_W-1:0] t_idx;

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PERM_DEPTH)
  ) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // handshake and shared datapath terms
  assign in_ready_o = ((state_q == ST_IDLE) && room_i.idle_ok) ||
                      ((state_q == ST_PD) && room_i.finish_ok);
  assign accept     = in_valid_i && in_ready_o;
  assign key_byte   = key_i[{n_q[3:0], 3'b000} +: BYTE_W];
  assign rd_si      = fwd_q ? si_q : ram_rdata;
  // keystream entry hit by the swap: s[i] now holds old s[j], s[j] still
  // waits for its write of old s[i]
  assign ks         = fwd2_q ? sj_q : (fwd3_q ? si_q : ram_rdata);
  assign i_next     = BYTE_W'(i_q + 1'b1);
  assign t_idx      = BYTE_W'(si_q + ram_rdata);

  // next state and ram port control
  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    i_d        = i_q;
    j_d        = j_q;
    si_d       = si_q;
    sj_d       = sj_q;
    data_d     = data_q;
    fwd_d      = fwd_q;
    fwd2_d     = fwd2_q;
    fwd3_d     = fwd3_q;
    ram_we     = 1'b0;
    ram_waddr  = n_q;
    ram_wdata  = n_q;
    ram_raddr  = i_next;
    res_o.valid = 1'b0;
    res_o.data  = data_q ^ ks;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          data_d = data_i;
          if (restart_i) begin
            n_d     = '0;
            state_d = ST_INIT;
          end else begin
            ram_raddr = i_next;
            i_d       = i_next;
            fwd_d     = 1'b0;
            state_d   = ST_PB;
          end
        end
      end
      // identity fill, one entry a cycle
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = n_q;
        ram_wdata = n_q;
        n_d       = BYTE_W'(n_q + 1'b1);
        if (n_q == LastIdx) begin
          j_d     = '0;
          state_d = ST_KA;
        end
      end
      // key schedule: read s[n]
      ST_KA: begin
        ram_raddr = n_q;
        state_d   = ST_KB;
      end
      // key schedule: new j, read s[j]
      ST_KB: begin
        si_d      = ram_rdata;
        j_d       = BYTE_W'(j_q + ram_rdata + key_byte);
        ram_raddr = BYTE_W'(j_q + ram_rdata + key_byte);
        state_d   = ST_KC;
      end
      // key schedule: s[n] <= s[j]
      ST_KC: begin
        ram_we    = 1'b1;
        ram_waddr = n_q;
        ram_wdata = ram_rdata;
        state_d   = ST_KD;
      end
      // key schedule: s[j] <= old s[n]
      ST_KD: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = si_q;
        n_d       = BYTE_W'(n_q + 1'b1);
        if (n_q == LastIdx) begin
          i_d     = '0;
          j_d     = '0;
          state_d = ST_PA;
        end else begin
          state_d = ST_KA;
        end
      end
      // first generator read after the key schedule
      ST_PA: begin
        ram_raddr = i_next;
        i_d       = i_next;
        fwd_d     = 1'b0;
        state_d   = ST_PB;
      end
      // generator: new j, read s[j]
      ST_PB: begin
        si_d      = rd_si;
        j_d       = BYTE_W'(j_q + rd_si);
        ram_raddr = BYTE_W'(j_q + rd_si);
        state_d   = ST_PC;
      end
      // generator: s[i] <= s[j], read keystream entry
      ST_PC: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
        sj_d      = ram_rdata;
        ram_raddr = t_idx;
        fwd2_d    = (t_idx == i_q);
        fwd3_d    = (t_idx == j_q);
        state_d   = ST_PD;
      end
      // generator: s[j] <= s[i], push result, maybe take the next byte
      ST_PD: begin
        ram_we      = 1'b1;
        ram_waddr   = j_q;
        ram_wdata   = si_q;
        res_o.valid = 1'b1;
        if (accept) begin
          data_d = data_i;
          if (restart_i) begin
            n_d     = '0;
            state_d = ST_INIT;
          end else begin
            ram_raddr = i_next;
            i_d       = i_next;
            fwd_d     = (i_next == j_q);
            state_d   = ST_PB;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      fwd_q   <= 1'b0;
      fwd2_q  <= 1'b0;
      fwd3_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      i_q     <= i_d;
      j_q     <= j_d;
      fwd_q   <= fwd_d;
      fwd2_q  <= fwd2_d;
      fwd3_q  <= fwd3_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    si_q   <= si_d;
    sj_q   <= sj_d;
    data_q <= data_d;
  end

endmodule

// ----- test/rc4_keystream_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 keystream checker
// Watches the key, input and output transfers of the cipher, keeps its own
// copy of the key, permutation and indices, predicts every output byte and
// compares it against the oldest prediction in flight.
// ----------------------------------------------------------------------------

module rc4_keystream_checker
  import rc4_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [BYTE_W-1:0] data_in_i,
  input  logic              restart_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [BYTE_W-1:0] data_out_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic              cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  // shadow of the cipher state
  logic [KEY_W-1:0]  key_bits;
  logic [BYTE_W-1:0] perm [PERM_DEPTH];
  logic [BYTE_W-1:0] ptr_i;
  logic [BYTE_W-1:0] ptr_j;

  logic [BYTE_W-1:0] expected_cipher [$];
  logic [BYTE_W-1:0] predicted;
  logic [BYTE_W-1:0] oldest;
  int unsigned       fails;

  // swap two permutation entries, a swap with itself leaves the entry alone
  task automatic swap_perm(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] t;
    t       = perm[a];
    perm[a] = perm[b];
    perm[b] = t;
  endtask

  // one generator step, preceded by the key schedule on a restart byte
  task automatic cipher_byte(input  logic [BYTE_W-1:0] din,
                             input  logic              rekey,
                             output logic [BYTE_W-1:0] dout);
    logic [BYTE_W-1:0] j;
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] kb;
    int                n;
    if (rekey) begin
      for (n = 0; n < PERM_DEPTH; n++) perm[n] = n[BYTE_W-1:0];
      j = '0;
      for (n = 0; n < PERM_DEPTH; n++) begin
        // key bytes repeat every 16 entries, low register first
        kb = key_bits[BYTE_W*n[3:0] +: BYTE_W];
        j  = j + perm[n] + kb;
        swap_perm(n[BYTE_W-1:0], j);
      end
      ptr_i = '0;
      ptr_j = '0;
    end
    ptr_i = ptr_i + 1'b1;
    ptr_j = ptr_j + perm[ptr_i];
    swap_perm(ptr_i, ptr_j);
    sum  = perm[ptr_i] + perm[ptr_j];
    dout = din ^ perm[sum];
  endtask

  // track transfers on all three channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_bits = '0;
      ptr_i    = '0;
      ptr_j    = '0;
      fails    = 0;
      expected_cipher.delete();
      foreach (perm[n]) perm[n] = '0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // key register write
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_KEY_LOW:  key_bits[CFG_W-1:0]     = cfg_data_i;
          CFG_KEY_HIGH: key_bits[KEY_W-1:CFG_W] = cfg_data_i;
          default: ;
        endcase
      end

      // output byte against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (expected_cipher.size() == 0) begin
          $error("data_out: no byte expected, actual %02h", data_out_i);
          fails++;
        end else begin
          oldest = expected_cipher.pop_front();
          if (data_out_i !== oldest) begin
            $error("data_out: expected %02h, actual %02h", oldest, data_out_i);
            fails++;
          end
        end
      end

      // input byte, predict its output
      if (in_valid_i && in_ready_i) begin
        cipher_byte(data_in_i, restart_i, predicted);
        expected_cipher.push_back(predicted);
      end

      fail_count_o <= fails;
      pending_o    <= expected_cipher.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 stream cipher testbench
// Directed key and data extremes, key changes in the middle of a message and
// repeated restarts, then random messages under random keys, with random
// gaps on the input and random stalls on the output. Output bytes are
// checked by a separate keystream checker.
// ----------------------------------------------------------------------------

module testbench
  import rc4_pkg::*;
();

  localparam int unsigned RANDOM_BYTES = 400;
  localparam int unsigned MAX_GAP      = 10;
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [BYTE_W-1:0] data_in_i   = '0;
  logic              restart_i   = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [BYTE_W-1:0] data_out_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i = CFG_KEY_LOW;
  logic [CFG_W-1:0]  cfg_data_i  = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned rx_hold;
  int unsigned random_sent;
  logic        calm = 1'b0;

  always #5 clk_i = ~clk_i;

  rc4_stream_cipher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_in_i   (data_in_i),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_out_o  (data_out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  rc4_keystream_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .data_in_i    (data_in_i),
    .restart_i    (restart_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .data_out_i   (data_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // idle cycles before the next transfer, none in a calm stretch
  function automatic int unsigned gap_cycles();
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // output side: random stall after each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid_o && out_ready_i) rx_hold = gap_cycles();
      if (rx_hold != 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // run length guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // one input byte; valid stays high afterwards until the caller sends the
  // next byte or ends the burst in the same step
  task automatic send_byte(input logic [BYTE_W-1:0] data, input logic rekey);
    int unsigned gap;
    gap = gap_cycles();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_in_i  <= data;
    restart_i  <= rekey;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
  endtask

  // hold off until every predicted byte has come out
  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // both key registers, only while the cipher is idle
  task automatic write_key(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_KEY_LOW;
    cfg_data_i  <= lo;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_KEY_HIGH;
    cfg_data_i  <= hi;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned      len;
    int unsigned      sel;
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-zero key, back to back; key schedule swaps entry 0 with itself
    calm <= 1'b1;
    write_key('0, '0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    end_burst();
    drain();

    // all-ones key with data extremes
    calm <= 1'b0;
    write_key('1, '1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    end_burst();
    drain();

    // new key mid-message: old stream continues until the next restart
    write_key(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    send_byte(8'h3c, 1'b0);
    send_byte(8'hc3, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h80, 1'b0);
    end_burst();
    drain();

    // restarts back to back and inside a message
    calm <= 1'b1;
    send_byte(8'h7f, 1'b1);
    send_byte(8'h7f, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h5a, 1'b0);
    end_burst();
    drain();

    // random messages under random keys
    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) != 0) begin
        sel = $urandom_range(0, 7);
        lo  = {$urandom, $urandom};
        hi  = {$urandom, $urandom};
        if (sel == 0) begin
          lo = '0;
          hi = '0;
        end else if (sel == 1) begin
          lo = '1;
          hi = '1;
        end
        write_key(lo, hi);
      end
      calm <= ($urandom_range(0, 3) == 0);
      len = $urandom_range(8, 40);
      for (int unsigned k = 0; k < len; k++) begin
        if (k == 0) send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) != 0);
        else        send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
      end
      random_sent += len;
      end_burst();
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rc4_pkg.sv
rtl/core/rc4_ram.sv
rtl/core/rc4_engine.sv
rtl/core/rc4_stream_cipher.sv
test/rc4_keystream_checker.sv
test/testbench.sv
